// ----- design/fgp_pkg.sv -----
// ----------------------------------------------------------------------------
// fgp_pkg
// Shared widths, reset values, register indexes, state codes and the
// structures exchanged between the frame gradient meter and its divider.
// ----------------------------------------------------------------------------
package fgp_pkg;

   // Payload and register widths.
   localparam int PIXEL_W     = 8;
   localparam int CFG_DIM_W   = 13;
   localparam int DIM_W       = CFG_DIM_W + 1;
   localparam int LW_W        = 4;
   localparam int TW_W        = 5;
   localparam int LUMA_W      = 33;
   localparam int CHROMA_W    = 31;
   localparam int GPP_W       = 22;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = CFG_DIM_W;

   // Blend and division widths.
   localparam int FRAC_W      = 8;
   localparam int NUM_W       = LUMA_W + LW_W + 1;
   localparam int DVD_W       = NUM_W + FRAC_W;
   localparam int AREA_W      = 2 * DIM_W;
   localparam int DEN_W       = AREA_W + TW_W;
   localparam int DIFF_W      = PIXEL_W + 1;

   // Size limits and register reset values.
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int MIN_DIM        = 2;
   localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = CFG_DIM_W'(1920);
   localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = CFG_DIM_W'(1088);
   localparam logic [LW_W-1:0]      RST_LUMA_WEIGHT  = LW_W'(4);
   localparam logic [TW_W-1:0]      RST_TOTAL_WEIGHT = TW_W'(6);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_LUMA_WEIGHT  = 2'd2,
      CSR_TOTAL_WEIGHT = 2'd3
   } csr_index_type;

   // Divider sequencer states.
   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_SCALE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // Request from the frame logic to the divider.
   typedef struct packed {
      logic                start;
      logic [LUMA_W-1:0]   luma_sum;
      logic [CHROMA_W-1:0] cb_sum;
      logic [CHROMA_W-1:0] cr_sum;
      logic [LW_W-1:0]     luma_weight;
      logic [TW_W-1:0]     total_weight;
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
   } div_req_type;

   // Answer from the divider.
   typedef struct packed {
      logic             done;
      logic [GPP_W-1:0] gpp_q8;
   } div_rsp_type;

endpackage

// ----- design/fgp_req_if.sv -----
// ----------------------------------------------------------------------------
// fgp_req_if
// Input channel: one sample byte per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fgp_req_if;

   logic                        valid;
   logic                        ready;
   logic [fgp_pkg::PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);

endinterface

// ----- design/fgp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fgp_rsp_if
// Result channel: the three gradient sums and the blended figure of a frame.
// ----------------------------------------------------------------------------
interface fgp_rsp_if;

   logic                         valid;
   logic                         ready;
   logic [fgp_pkg::LUMA_W-1:0]   luma_sum;
   logic [fgp_pkg::CHROMA_W-1:0] cb_sum;
   logic [fgp_pkg::CHROMA_W-1:0] cr_sum;
   logic [fgp_pkg::GPP_W-1:0]    gpp_q8;

   modport source (output valid, output luma_sum, output cb_sum, output cr_sum,
                   output gpp_q8, input ready);
   modport sink   (input valid, input luma_sum, input cb_sum, input cr_sum,
                   input gpp_q8, output ready);

endinterface

// ----- design/frame_gradient_per_pixel.sv -----
// ----------------------------------------------------------------------------
// frame_gradient_per_pixel
// Gradient activity meter for one 4:2:0 semi-planar frame per result.
// The result is valid once the last chroma byte has passed the accumulate
// stage, the divider start register and the divider's idle, scale, run and
// done states. One byte per cycle inside a frame; the line store is read and
// written at the same address in the accept cycle, with the sums one stage
// on. After the last chroma byte input stalls until the result item is taken.
// Reset (synchronous) clears position, sums and registers; the line store is
// left as it is, entries are rewritten before they are read.
// ----------------------------------------------------------------------------
module frame_gradient_per_pixel #(
   parameter int MAX_WIDTH  = fgp_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fgp_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   fgp_req_if.sink                        req_ch,
   fgp_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [fgp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fgp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int DW = fgp_pkg::DIM_W;

   // Configuration registers.
   logic [fgp_pkg::CFG_DIM_W-1:0] frame_width_ff;
   logic [fgp_pkg::CFG_DIM_W-1:0] frame_height_ff;
   logic [fgp_pkg::LW_W-1:0]      luma_weight_ff;
   logic [fgp_pkg::TW_W-1:0]      total_weight_ff;

   // Scan position and sample history.
   logic [CW-1:0]               col_ff, col_in;
   logic [RW-1:0]               row_ff, row_in;
   logic                        chroma_ff, chroma_in;
   logic [fgp_pkg::PIXEL_W-1:0] prev_ff;
   logic [fgp_pkg::PIXEL_W-1:0] prev2_ff;
   logic                        busy_ff, busy_in;

   // Accumulate stage.
   logic                        s1_valid_ff;
   logic [fgp_pkg::PIXEL_W-1:0] s1_px_ff;
   logic [fgp_pkg::PIXEL_W-1:0] s1_nbr_ff;
   logic                        s1_horiz_ff;
   logic                        s1_vert_ff;
   logic                        s1_chroma_ff;
   logic                        s1_cr_ff;
   logic                        s1_emit_ff;

   logic [fgp_pkg::LUMA_W-1:0]   luma_acc_ff, luma_acc_in;
   logic [fgp_pkg::CHROMA_W-1:0] cb_acc_ff, cb_acc_in;
   logic [fgp_pkg::CHROMA_W-1:0] cr_acc_ff, cr_acc_in;

   // Result holding registers.
   logic                         div_start_ff;
   logic                         rsp_valid_ff;
   logic [fgp_pkg::LUMA_W-1:0]   rsp_luma_ff;
   logic [fgp_pkg::CHROMA_W-1:0] rsp_cb_ff;
   logic [fgp_pkg::CHROMA_W-1:0] rsp_cr_ff;
   logic [fgp_pkg::GPP_W-1:0]    rsp_gpp_ff;

   logic [DW-1:0]               width;
   logic [DW-1:0]               height;
   logic [DW-1:0]               rows;
   logic [DW-1:0]               col_ext;
   logic [DW-1:0]               row_ext;
   logic [DW-1:0]               col_next;
   logic [DW-1:0]               row_next;
   logic                        last_row;
   logic                        horiz;
   logic                        vert;
   logic                        emit;
   logic                        accept;
   logic [fgp_pkg::PIXEL_W-1:0] line_data;
   logic [fgp_pkg::DIFF_W-1:0]  diff_h;
   logic [fgp_pkg::DIFF_W-1:0]  diff_v;
   logic [fgp_pkg::DIFF_W-1:0]  grad;
   logic [fgp_pkg::PIXEL_W-1:0] abs_h;
   logic [fgp_pkg::PIXEL_W-1:0] abs_v;

   fgp_pkg::div_req_type div_req;
   fgp_pkg::div_rsp_type div_rsp;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= fgp_pkg::RST_FRAME_WIDTH;
         frame_height_ff <= fgp_pkg::RST_FRAME_HEIGHT;
         luma_weight_ff  <= fgp_pkg::RST_LUMA_WEIGHT;
         total_weight_ff <= fgp_pkg::RST_TOTAL_WEIGHT;
      end else if (csr_wr_en) begin
         unique case (fgp_pkg::csr_index_type'(csr_index))
            fgp_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            fgp_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            fgp_pkg::CSR_LUMA_WEIGHT:  luma_weight_ff  <= csr_wdata[fgp_pkg::LW_W-1:0];
            fgp_pkg::CSR_TOTAL_WEIGHT: total_weight_ff <= csr_wdata[fgp_pkg::TW_W-1:0];
            default: ;
         endcase
      end
   end

   // Frame size clamped to the supported range.
   always_comb begin
      if (frame_width_ff < fgp_pkg::CFG_DIM_W'(fgp_pkg::MIN_DIM))
         width = DW'(fgp_pkg::MIN_DIM);
      else if ({1'b0, frame_width_ff} > DW'(MAX_WIDTH))
         width = DW'(MAX_WIDTH);
      else
         width = {1'b0, frame_width_ff};
      if (frame_height_ff < fgp_pkg::CFG_DIM_W'(fgp_pkg::MIN_DIM))
         height = DW'(fgp_pkg::MIN_DIM);
      else if ({1'b0, frame_height_ff} > DW'(MAX_HEIGHT))
         height = DW'(MAX_HEIGHT);
      else
         height = {1'b0, frame_height_ff};
   end

   // No item is taken while reset is held.
   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !busy_ff && !reset;

   // Neighbor selection for the incoming sample.
   assign rows     = chroma_ff ? (height >> 1) : height;
   assign col_ext  = DW'(col_ff);
   assign row_ext  = DW'(row_ff);
   assign col_next = col_ext + DW'(1);
   assign row_next = row_ext + DW'(1);
   assign last_row = row_next >= rows;

   always_comb begin
      if (chroma_ff) begin
         horiz = (col_ext >= DW'(2)) && (col_ext < width) && !last_row;
         vert  = (row_ff != '0) && ((col_ext + DW'(2)) < width);
      end else begin
         horiz = (col_ext >= DW'(1)) && (col_ext < width) && !last_row;
         vert  = (row_ff != '0) && (col_next < width);
      end
   end

   // Scan advance: column, then row, then plane.
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      chroma_in = chroma_ff;
      emit      = 1'b0;
      if (col_next >= width) begin
         col_in = '0;
         if (row_next >= rows) begin
            row_in    = '0;
            chroma_in = !chroma_ff;
            emit      = chroma_ff;
         end else begin
            row_in = RW'(row_next);
         end
      end else begin
         col_in = CW'(col_next);
      end
   end

   // Stall from the last byte of a frame until its result is taken.
   always_comb begin
      busy_in = busy_ff;
      if (accept && emit)
         busy_in = 1'b1;
      else if (rsp_ch.valid && rsp_ch.ready)
         busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         chroma_ff   <= 1'b0;
         prev_ff     <= '0;
         prev2_ff    <= '0;
         busy_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff    <= col_in;
            row_ff    <= row_in;
            chroma_ff <= chroma_in;
            prev_ff   <= req_ch.pixel;
            prev2_ff  <= prev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff     <= req_ch.pixel;
         s1_nbr_ff    <= chroma_ff ? prev2_ff : prev_ff;
         s1_horiz_ff  <= horiz;
         s1_vert_ff   <= vert;
         s1_chroma_ff <= chroma_ff;
         s1_cr_ff     <= col_ff[0];
         s1_emit_ff   <= emit;
      end
   end

   fgp_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .access  (accept),
      .addr    (col_ff),
      .wr_data (req_ch.pixel),
      .rd_data (line_data)
   );

   // Absolute differences to the left and upper neighbors.
   assign diff_h = {1'b0, s1_nbr_ff} - {1'b0, s1_px_ff};
   assign diff_v = {1'b0, line_data} - {1'b0, s1_px_ff};
   assign abs_h  = diff_h[fgp_pkg::PIXEL_W] ? (s1_px_ff - s1_nbr_ff) : diff_h[fgp_pkg::PIXEL_W-1:0];
   assign abs_v  = diff_v[fgp_pkg::PIXEL_W] ? (s1_px_ff - line_data) : diff_v[fgp_pkg::PIXEL_W-1:0];
   assign grad   = (s1_horiz_ff ? {1'b0, abs_h} : '0) + (s1_vert_ff ? {1'b0, abs_v} : '0);

   // Sum update; chroma goes by column parity.
   always_comb begin
      luma_acc_in = luma_acc_ff;
      cb_acc_in   = cb_acc_ff;
      cr_acc_in   = cr_acc_ff;
      if (!s1_chroma_ff)
         luma_acc_in = luma_acc_ff + fgp_pkg::LUMA_W'(grad);
      else if (s1_cr_ff)
         cr_acc_in = cr_acc_ff + fgp_pkg::CHROMA_W'(grad);
      else
         cb_acc_in = cb_acc_ff + fgp_pkg::CHROMA_W'(grad);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_acc_ff  <= '0;
         cb_acc_ff    <= '0;
         cr_acc_ff    <= '0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= s1_valid_ff && s1_emit_ff;
         if (s1_valid_ff) begin
            if (s1_emit_ff) begin
               luma_acc_ff <= '0;
               cb_acc_ff   <= '0;
               cr_acc_ff   <= '0;
            end else begin
               luma_acc_ff <= luma_acc_in;
               cb_acc_ff   <= cb_acc_in;
               cr_acc_ff   <= cr_acc_in;
            end
         end
      end
   end

   // Frame totals are held here until the result item is taken.
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_emit_ff) begin
         rsp_luma_ff <= luma_acc_in;
         rsp_cb_ff   <= cb_acc_in;
         rsp_cr_ff   <= cr_acc_in;
      end
      if (div_rsp.done)
         rsp_gpp_ff <= div_rsp.gpp_q8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_rsp.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign div_req.start        = div_start_ff;
   assign div_req.luma_sum     = rsp_luma_ff;
   assign div_req.cb_sum       = rsp_cb_ff;
   assign div_req.cr_sum       = rsp_cr_ff;
   assign div_req.luma_weight  = luma_weight_ff;
   assign div_req.total_weight = total_weight_ff;
   assign div_req.width        = width;
   assign div_req.height       = height;

   fgp_gpp_div u_gpp_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.luma_sum = rsp_luma_ff;
   assign rsp_ch.cb_sum   = rsp_cb_ff;
   assign rsp_ch.cr_sum   = rsp_cr_ff;
   assign rsp_ch.gpp_q8   = rsp_gpp_ff;

endmodule

// ----- design/fgp_line_mem.sv -----
// ----------------------------------------------------------------------------
// fgp_line_mem
// Single-port line store. A read and a write to the same address in one
// cycle return the old contents, so the previous row is read as the new
// sample replaces it.
// ----------------------------------------------------------------------------
module fgp_line_mem #(
   parameter int DEPTH = fgp_pkg::DEF_MAX_WIDTH
) (
   input  logic                        clock,
   input  logic                        access,
   input  logic [$clog2(DEPTH)-1:0]    addr,
   input  logic [fgp_pkg::PIXEL_W-1:0] wr_data,
   output logic [fgp_pkg::PIXEL_W-1:0] rd_data
);

   logic [fgp_pkg::PIXEL_W-1:0] store_ff [DEPTH];
   logic [fgp_pkg::PIXEL_W-1:0] rd_data_ff;

   // Read-first access: old row sample out, new sample in.
   always_ff @(posedge clock) begin
      if (access) begin
         rd_data_ff    <= store_ff[addr];
         store_ff[addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/fgp_gpp_div.sv -----
// ----------------------------------------------------------------------------
// fgp_gpp_div
// Per-frame blend: forms the weighted numerator and the frame area times the
// total weight, then a restoring divider yields one quotient bit per cycle.
// The quotient saturates to the width of the result.
// ----------------------------------------------------------------------------
module fgp_gpp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fgp_pkg::div_req_type req,
   output fgp_pkg::div_rsp_type rsp
);

   localparam int CNT_W = $clog2(fgp_pkg::DVD_W);

   fgp_pkg::div_state_type state_ff, state_in;

   logic load_operands;
   logic load_den;
   logic step;
   logic done;

   logic [fgp_pkg::AREA_W-1:0] area_ff;
   logic [fgp_pkg::TW_W-1:0]   tw_ff;
   logic [fgp_pkg::DEN_W-1:0]  den_ff;
   logic [fgp_pkg::DVD_W-1:0]  quo_ff;
   logic [fgp_pkg::DEN_W-1:0]  rem_ff;
   logic [CNT_W-1:0]           cnt_ff;

   logic [fgp_pkg::CHROMA_W:0] chroma_total;
   logic [fgp_pkg::NUM_W-1:0]  num;
   logic [fgp_pkg::DEN_W:0]    rem_shift;
   logic [fgp_pkg::DEN_W:0]    trial;
   logic                       fits;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fgp_pkg::DIV_IDLE:  if (req.start) state_in = fgp_pkg::DIV_SCALE;
         fgp_pkg::DIV_SCALE: state_in = fgp_pkg::DIV_RUN;
         fgp_pkg::DIV_RUN:   if (cnt_ff == '0) state_in = fgp_pkg::DIV_DONE;
         fgp_pkg::DIV_DONE:  state_in = fgp_pkg::DIV_IDLE;
         default:            state_in = fgp_pkg::DIV_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      load_operands = 1'b0;
      load_den      = 1'b0;
      step          = 1'b0;
      done          = 1'b0;
      unique case (state_ff)
         fgp_pkg::DIV_IDLE:  load_operands = req.start;
         fgp_pkg::DIV_SCALE: load_den      = 1'b1;
         fgp_pkg::DIV_RUN:   step          = 1'b1;
         fgp_pkg::DIV_DONE:  done          = 1'b1;
         default:            done          = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fgp_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Weighted numerator: lw * Y + 4 * (Cb + Cr).
   assign chroma_total = {1'b0, req.cb_sum} + {1'b0, req.cr_sum};
   assign num = fgp_pkg::NUM_W'(req.luma_sum) * fgp_pkg::NUM_W'(req.luma_weight)
              + fgp_pkg::NUM_W'({chroma_total, 2'b00});

   // One restoring step: shift in the next dividend bit and try the subtract.
   assign rem_shift = {rem_ff, quo_ff[fgp_pkg::DVD_W-1]};
   assign trial     = rem_shift - {1'b0, den_ff};
   assign fits      = !trial[fgp_pkg::DEN_W];

   always_ff @(posedge clock) begin
      if (load_operands) begin
         area_ff <= fgp_pkg::AREA_W'(req.width) * fgp_pkg::AREA_W'(req.height);
         tw_ff   <= req.total_weight;
         quo_ff  <= {num, fgp_pkg::FRAC_W'(0)};
      end
      if (load_den) begin
         den_ff <= fgp_pkg::DEN_W'(area_ff) * fgp_pkg::DEN_W'(tw_ff);
         rem_ff <= '0;
         cnt_ff <= CNT_W'(fgp_pkg::DVD_W - 1);
      end
      if (step) begin
         rem_ff <= fits ? trial[fgp_pkg::DEN_W-1:0] : rem_shift[fgp_pkg::DEN_W-1:0];
         quo_ff <= {quo_ff[fgp_pkg::DVD_W-2:0], fits};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   // A zero divisor or a quotient beyond the result width gives all ones.
   assign rsp.done   = done;
   assign rsp.gpp_q8 = ((den_ff == '0) || (|quo_ff[fgp_pkg::DVD_W-1:fgp_pkg::GPP_W]))
                     ? '1 : quo_ff[fgp_pkg::GPP_W-1:0];

endmodule

// ----- design/fgp_checker.sv -----
// ----------------------------------------------------------------------------
// fgp_checker
// Port-level checks on the frame gradient meter, bound to the top level.
// ----------------------------------------------------------------------------
module fgp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [fgp_pkg::LUMA_W-1:0]   rsp_luma_sum,
   input logic [fgp_pkg::CHROMA_W-1:0] rsp_cb_sum,
   input logic [fgp_pkg::CHROMA_W-1:0] rsp_cr_sum,
   input logic [fgp_pkg::GPP_W-1:0]    rsp_gpp_q8
);

   // A pending result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result item dropped while stalled");

   // The offered result does not change while it waits.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_luma_sum) && $stable(rsp_cb_sum)
                                     && $stable(rsp_cr_sum) && $stable(rsp_gpp_q8)))
      else $error("result payload changed while stalled");

   // No new sample is taken while a frame result is waiting.
   a_no_input_while_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result is pending");

   // A frame result is never followed directly by another.
   a_no_back_to_back_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("second result without a new frame");

endmodule

bind frame_gradient_per_pixel fgp_checker u_fgp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_luma_sum (rsp_ch.luma_sum),
   .rsp_cb_sum   (rsp_ch.cb_sum),
   .rsp_cr_sum   (rsp_ch.cr_sum),
   .rsp_gpp_q8   (rsp_ch.gpp_q8)
);
